FILE: sv/gamepad_edge_repeat_qualifier_assert.svh
// Assertion macros shared by the key qualifier modules.
// Every macro expects clk and rst_n in scope and is used on a line of its own.
`ifndef GAMEPAD_EDGE_REPEAT_QUALIFIER_ASSERT_SVH
`define GAMEPAD_EDGE_REPEAT_QUALIFIER_ASSERT_SVH

// Same-cycle implication
`define GERQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define GERQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/gerq_pkg.sv
package gerq_pkg;

  // Key vector layout: hat U,R,D,L, left stick, right stick, then buttons
  localparam int KEY_COUNT       = 28;
  localparam int HAT_KEY_BASE    = 0;
  localparam int LSTICK_KEY_BASE = 4;
  localparam int RSTICK_KEY_BASE = 8;
  localparam int BTN_KEY_BASE    = 12;
  localparam int BTN_KEY_COUNT   = KEY_COUNT - BTN_KEY_BASE;
  localparam int NUM_BUTTONS_DEF = 16;

  // Hat quantisation step, hundredths of a degree
  localparam int HAT_STEP  = 4500;
  localparam int HAT_SECTS = 8;

  // Config widths and reset values
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [7:0]  REPEAT_PERIOD_RST = 8'd25;
  localparam logic [15:0] AXIS_CENTER_RST   = 16'h7fff;
  localparam logic [14:0] AXIS_OFFSET_RST   = 15'h4000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_REPEAT_PERIOD = 2'd0,
    CFG_AXIS_CENTER   = 2'd1,
    CFG_AXIS_OFFSET   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]  repeat_period;
    logic [15:0] axis_center;
    logic [14:0] axis_offset;
  } cfg_t;

  typedef struct packed {
    logic        sample_ok;
    logic [15:0] left_x;
    logic [15:0] left_y;
    logic [15:0] right_x;
    logic [15:0] right_y;
    logic [15:0] hat_angle;
    logic [15:0] button_mask;
  } in_item_t;

  typedef struct packed {
    logic [KEY_COUNT-1:0] pressed_keys;
    logic [KEY_COUNT-1:0] triggered_keys;
    logic [KEY_COUNT-1:0] released_keys;
    logic [KEY_COUNT-1:0] held_keys;
    logic [KEY_COUNT-1:0] repeated_keys;
  } out_item_t;

  // Hat sector patterns, last entry is centred
  localparam logic [3:0] HAT_PATTERN [HAT_SECTS+1] = '{
    4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hc, 4'h8, 4'h9, 4'h0
  };

  // Hat angle to U,R,D,L keys; quotient by 4500 via a row of compares
  function automatic logic [3:0] hat_keys(input logic [15:0] angle);
    logic [3:0] sect;
    sect = '0;
    for (int k = 1; k <= HAT_SECTS; k++) begin
      if (angle >= 16'(HAT_STEP * k)) begin
        sect = 4'(k);
      end
    end
    return HAT_PATTERN[sect];
  endfunction

endpackage

FILE: sv/gerq_keymap.sv
module gerq_keymap
  import gerq_pkg::*;
#(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
  input  in_item_t             item,
  input  cfg_t                 cfg,
  output logic [KEY_COUNT-1:0] keys
);

  localparam int BTN_USED = (NUM_BUTTONS < BTN_KEY_COUNT) ? NUM_BUTTONS : BTN_KEY_COUNT;

  logic [16:0]          bound_hi;
  logic signed [17:0]   bound_lo;
  logic [3:0]           lstick;
  logic [3:0]           rstick;
  logic [BTN_KEY_COUNT-1:0] btn_keep;

  // Threshold bounds, no wrap: a negative lower bound is never met
  assign bound_hi = {1'b0, cfg.axis_center} + {2'b0, cfg.axis_offset};
  assign bound_lo = $signed({2'b0, cfg.axis_center}) - $signed({3'b0, cfg.axis_offset});

  function automatic logic [3:0] stick_keys(input logic [15:0] x, input logic [15:0] y,
                                            input logic [16:0] hi,
                                            input logic signed [17:0] lo);
    logic [3:0] k;
    k[0] = $signed({2'b0, y}) < lo;
    k[1] = {1'b0, x} > hi;
    k[2] = {1'b0, y} > hi;
    k[3] = $signed({2'b0, x}) < lo;
    return k;
  endfunction

  assign lstick = stick_keys(item.left_x, item.left_y, bound_hi, bound_lo);
  assign rstick = stick_keys(item.right_x, item.right_y, bound_hi, bound_lo);

  // Buttons beyond the configured count are dropped
  for (genvar i = 0; i < BTN_KEY_COUNT; i++) begin : g_btn
    assign btn_keep[i] = (i < BTN_USED);
  end

  always_comb begin
    keys = '0;
    keys[HAT_KEY_BASE +: 4]    = hat_keys(item.hat_angle);
    keys[LSTICK_KEY_BASE +: 4] = lstick;
    keys[RSTICK_KEY_BASE +: 4] = rstick;
    keys[BTN_KEY_BASE +: BTN_KEY_COUNT] = item.button_mask[BTN_KEY_COUNT-1:0] & btn_keep;
  end

endmodule

FILE: sv/gerq_repeat.sv
`include "gamepad_edge_repeat_qualifier_assert.svh"

module gerq_repeat
  import gerq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 upd,
  input  logic [7:0]           period,
  input  logic [KEY_COUNT-1:0] cur,
  input  logic [KEY_COUNT-1:0] prev,
  output out_item_t            res
);

  logic [7:0]           cnt_r   [KEY_COUNT];
  logic [7:0]           cnt_nxt [KEY_COUNT];
  logic [KEY_COUNT-1:0] cnt_nz;
  logic [KEY_COUNT-1:0] trig;
  logic [KEY_COUNT-1:0] rel;
  logic [KEY_COUNT-1:0] hold;
  logic [KEY_COUNT-1:0] rep;

  // Edge classification against the previous poll
  assign trig = cur & ~prev;
  assign rel  = prev & ~cur;
  assign hold = cur & prev;

  // Per-key hold counter and autorepeat pulse
  for (genvar i = 0; i < KEY_COUNT; i++) begin : g_key
    logic at_period;
    assign cnt_nz[i] = (cnt_r[i] != 8'd0);
    assign at_period = (cnt_r[i] >= period);
    assign rep[i]    = cnt_nz[i] ? (at_period & hold[i]) : trig[i];

    always_comb begin
      cnt_nxt[i] = cnt_r[i];
      if (upd) begin
        if (hold[i]) begin
          cnt_nxt[i] = (cnt_nz[i] && at_period) ? 8'd1 : cnt_r[i] + 8'd1;
        end else if (rel[i]) begin
          cnt_nxt[i] = 8'd0;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cnt_r[i] <= 8'd0;
      end else begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

  assign res.pressed_keys   = cur;
  assign res.triggered_keys = trig;
  assign res.released_keys  = rel;
  assign res.held_keys      = hold;
  assign res.repeated_keys  = rep;

  // Counters run only for keys still down
  `GERQ_ASSERT_IMP(a_cnt_idle_zero, 1'b1, (cnt_nz & ~prev) == '0, "count on idle key")
  // A trigger always gives a repeat pulse
  `GERQ_ASSERT_IMP(a_trig_repeats, upd, (trig & ~rep) == '0, "trigger without repeat")

endmodule

FILE: sv/gamepad_edge_repeat_qualifier.sv
// An accepted item is registered in the input register, and its result is then
// registered in the result register, from which it is taken.
// Throughput: one item per cycle; the input register and the result register
// each hold one item, so the only limit is the result side's stall.
// Reset (synchronous, rst_n low): no items held, hold counters and last
// results cleared, registers back to period 25, centre 0x7fff, offset 0x4000.
`include "gamepad_edge_repeat_qualifier_assert.svh"

module gamepad_edge_repeat_qualifier
  import gerq_pkg::*;
#(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item
);

  cfg_t                 cfg_r, cfg_nxt;
  logic                 s1_valid_r, s1_valid_nxt;
  in_item_t             s1_item_r, s1_item_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_item_r, out_item_nxt;
  logic                 out_ok;
  logic                 adv;
  logic                 upd;
  logic [KEY_COUNT-1:0] cur_keys;
  out_item_t            res;
  logic [KEY_COUNT-1:0] rep_stray;

  // Config writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_REPEAT_PERIOD: cfg_nxt.repeat_period = cfg_wdata[7:0];
        CFG_AXIS_CENTER:   cfg_nxt.axis_center   = cfg_wdata;
        CFG_AXIS_OFFSET:   cfg_nxt.axis_offset   = cfg_wdata[14:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  // Handshake: result slot free, input stage moves on
  assign out_ok   = !out_valid_r || !out_stall;
  assign adv      = s1_valid_r && out_ok;
  assign upd      = adv && s1_item_r.sample_ok;
  assign in_stall = s1_valid_r && !out_ok;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_item_nxt  = s1_item_r;
    if (!in_stall) begin
      s1_valid_nxt = in_valid;
      s1_item_nxt  = in_item;
    end
  end

  gerq_keymap #(
    .NUM_BUTTONS(NUM_BUTTONS)
  ) u_keymap (
    .item(s1_item_r),
    .cfg (cfg_r),
    .keys(cur_keys)
  );

  // Result register doubles as the last results; prev keys come from it
  gerq_repeat u_repeat (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (upd),
    .period(cfg_r.repeat_period),
    .cur   (cur_keys),
    .prev  (out_item_r.pressed_keys),
    .res   (res)
  );

  // A failed poll re-sends the last results unchanged
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
      if (s1_item_r.sample_ok) begin
        out_item_nxt = res;
      end
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.repeat_period <= REPEAT_PERIOD_RST;
      cfg_r.axis_center   <= AXIS_CENTER_RST;
      cfg_r.axis_offset   <= AXIS_OFFSET_RST;
      s1_valid_r          <= 1'b0;
      out_valid_r         <= 1'b0;
      out_item_r          <= '0;
    end else begin
      cfg_r       <= cfg_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      out_item_r  <= out_item_nxt;
    end
  end

  // Input stage payload
  always_ff @(posedge clk) begin
    s1_item_r <= s1_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Repeat bits on keys that are not down
  assign rep_stray = out_item_r.repeated_keys & ~out_item_r.pressed_keys;

  // Stall only with the input stage full
  `GERQ_ASSERT_IMP(a_stall_full, in_stall, s1_valid_r, "stall with empty stage")
  // A blocked input stage keeps its item
  `GERQ_ASSERT_NXT(a_s1_hold, in_stall, s1_valid_r && $stable(s1_item_r), "stage lost item")
  // Repeat pulses only on pressed keys
  `GERQ_ASSERT_IMP(a_rep_pressed, out_valid_r, rep_stray == '0, "repeat on released key")

endmodule
